>>> hdl/ple_pkg.sv
package ple_pkg;

   localparam int unsigned DATA_WIDTH   = 32;
   localparam int unsigned FUNC_WIDTH   = 3;
   localparam int unsigned POS_WIDTH    = 8;
   localparam int unsigned STATUS_WIDTH = 2;
   localparam int unsigned COUNT_WIDTH  = 7;

   // operation codes on req_func
   localparam logic [FUNC_WIDTH-1:0] FUNC_INSERT    = 3'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_OVERWRITE = 3'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_REMOVE    = 3'd2;
   localparam logic [FUNC_WIDTH-1:0] FUNC_READ      = 3'd3;
   localparam logic [FUNC_WIDTH-1:0] FUNC_CLEAR     = 3'd4;

   // status codes on rsp_status
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd2;

   // what every cell of the chain does this cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_WRITE
   } cell_op_type;

   typedef struct packed {
      cell_op_type                   op;
      logic signed [DATA_WIDTH-1:0] data;
   } cell_ctl_type;

endpackage

>>> hdl/ple_cell.sv
module ple_cell #(
   parameter int unsigned IDX_WIDTH = 6
) (
   input  logic                                   clock,
   input  ple_pkg::cell_ctl_type                  ctl,
   input  logic [IDX_WIDTH-1:0]                   idx,
   input  logic [IDX_WIDTH-1:0]                   cell_index,
   input  logic signed [ple_pkg::DATA_WIDTH-1:0]  left_value,
   input  logic signed [ple_pkg::DATA_WIDTH-1:0]  right_value,
   output logic signed [ple_pkg::DATA_WIDTH-1:0]  value,
   output logic signed [ple_pkg::DATA_WIDTH-1:0]  read_value
);
   import ple_pkg::*;

   logic signed [DATA_WIDTH-1:0] value_ff;
   logic signed [DATA_WIDTH-1:0] value_in;
   logic                         hit;
   logic                         above;

   assign hit   = (cell_index == idx);
   assign above = (cell_index > idx);

   always_comb begin
      value_in = value_ff;
      unique case (ctl.op)
         CELL_INSERT: begin
            if (above) begin
               value_in = left_value;   // make room: move up one place
            end else if (hit) begin
               value_in = ctl.data;
            end
         end
         CELL_REMOVE: begin
            if (above || hit) begin
               value_in = right_value;  // close the gap
            end
         end
         CELL_WRITE: begin
            if (hit) begin
               value_in = ctl.data;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value      = value_ff;
   assign read_value = hit ? value_ff : '0;

endmodule

>>> hdl/ple_chain.sv
module ple_chain #(
   parameter  int unsigned CAPACITY  = 64,
   localparam int unsigned IDX_WIDTH = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                                   clock,
   input  ple_pkg::cell_ctl_type                  ctl,
   input  logic [IDX_WIDTH-1:0]                   idx,
   output logic signed [ple_pkg::DATA_WIDTH-1:0]  read_value
);
   import ple_pkg::*;

   logic signed [DATA_WIDTH-1:0] cell_value [CAPACITY];
   logic signed [DATA_WIDTH-1:0] cell_read  [CAPACITY];
   logic signed [DATA_WIDTH-1:0] left_tap   [CAPACITY];
   logic signed [DATA_WIDTH-1:0] right_tap  [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_tap[i] = '0;
      end else begin : g_mid_l
         assign left_tap[i] = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_tap[i] = '0;
      end else begin : g_mid_r
         assign right_tap[i] = cell_value[i+1];
      end

      ple_cell #(
         .IDX_WIDTH (IDX_WIDTH)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .idx         (idx),
         .cell_index  (IDX_WIDTH'(i)),
         .left_value  (left_tap[i]),
         .right_value (right_tap[i]),
         .value       (cell_value[i]),
         .read_value  (cell_read[i])
      );
   end

   // at most one cell matches; the rest drive zero
   always_comb begin
      read_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_value = read_value | cell_read[i];
      end
   end

endmodule

>>> hdl/positional_list_engine.sv
// Channel   | Ports                                       | Transfer
// ----------+---------------------------------------------+-----------------------------
// request   | start, busy, req_func/position/value        | clock edge, start & !busy
// response  | rsp_strobe, rsp_read_value/status/count     | one cycle, rsp_strobe high
//
// One operation per clock: a request taken at one edge has its response on the
// rsp_ ports for the cycle after. busy stays low; every cell of the chain
// shifts, holds or loads in the same cycle, so insert and remove cost no more
// than read. Reset empties the list (count to zero) and drops a pending
// response; the cell contents are left as they are. The receiver cannot stall.
module positional_list_engine #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [ple_pkg::FUNC_WIDTH-1:0]        req_func,
   input  logic [ple_pkg::POS_WIDTH-1:0]         req_position,
   input  logic signed [ple_pkg::DATA_WIDTH-1:0] req_value,
   output logic                                  rsp_strobe,
   output logic signed [ple_pkg::DATA_WIDTH-1:0] rsp_read_value,
   output logic [ple_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output logic [ple_pkg::COUNT_WIDTH-1:0]       rsp_count
);
   import ple_pkg::*;

   localparam int unsigned IDX_WIDTH = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CNT_WIDTH = $clog2(CAPACITY + 1);
   // compare width: wide enough for both the position and the count, and for
   // the seven-bit count on the response
   localparam int unsigned CMP_WIDTH = (CNT_WIDTH > POS_WIDTH) ? CNT_WIDTH : POS_WIDTH;

   logic                         accept;

   // list occupancy
   logic [CNT_WIDTH-1:0]         count_ff;
   logic [CNT_WIDTH-1:0]         count_in;

   // response register
   logic                         rsp_strobe_ff;
   logic signed [DATA_WIDTH-1:0] rsp_read_value_ff;
   logic signed [DATA_WIDTH-1:0] rsp_read_value_in;
   logic [STATUS_WIDTH-1:0]      rsp_status_ff;
   logic [STATUS_WIDTH-1:0]      rsp_status_in;
   logic [COUNT_WIDTH-1:0]       rsp_count_ff;

   // position handling
   logic [CMP_WIDTH-1:0]         pos_ext;
   logic [CMP_WIDTH-1:0]         cnt_ext;
   logic [CMP_WIDTH-1:0]         ins_pos;
   logic [CMP_WIDTH-1:0]         clamp_pos;
   logic [CMP_WIDTH-1:0]         count_in_ext;
   logic                         beyond;
   logic                         empty;
   logic                         full;

   cell_ctl_type                 ctl;
   logic [IDX_WIDTH-1:0]         idx;
   logic signed [DATA_WIDTH-1:0] chain_read;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_WIDTH'(CAPACITY));

   // insert clamps to the tail slot, the others to the last element
   assign pos_ext   = CMP_WIDTH'(req_position);
   assign cnt_ext   = CMP_WIDTH'(count_ff);
   assign beyond    = (pos_ext >= cnt_ext);
   assign ins_pos   = beyond ? cnt_ext : pos_ext;
   assign clamp_pos = beyond ? (cnt_ext - CMP_WIDTH'(1)) : pos_ext;

   always_comb begin
      ctl.op            = CELL_HOLD;
      ctl.data          = req_value;
      idx               = clamp_pos[IDX_WIDTH-1:0];
      count_in          = count_ff;
      rsp_status_in     = STATUS_OK;
      rsp_read_value_in = '0;
      if (accept) begin
         unique case (req_func)
            FUNC_INSERT: begin
               idx = ins_pos[IDX_WIDTH-1:0];
               if (full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  ctl.op   = CELL_INSERT;
                  count_in = count_ff + CNT_WIDTH'(1);
               end
            end
            FUNC_OVERWRITE: begin
               if (empty) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  ctl.op = CELL_WRITE;
               end
            end
            FUNC_REMOVE: begin
               if (empty) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  // value leaves the chain in the same cycle as the shift
                  ctl.op            = CELL_REMOVE;
                  rsp_read_value_in = chain_read;
                  count_in          = count_ff - CNT_WIDTH'(1);
               end
            end
            FUNC_READ: begin
               if (empty) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  rsp_read_value_in = chain_read;
               end
            end
            FUNC_CLEAR: begin
               count_in = '0;
            end
            default: begin
               // unused codes: no change, status ok
               count_in = count_ff;
            end
         endcase
      end
   end

   assign count_in_ext = CMP_WIDTH'(count_in);

   ple_chain #(
      .CAPACITY (CAPACITY)
   ) u_chain (
      .clock      (clock),
      .ctl        (ctl),
      .idx        (idx),
      .read_value (chain_read)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
      // payload, no reset needed
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_count_ff      <= count_in_ext[COUNT_WIDTH-1:0];
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;

endmodule

>>> dv/positional_list_engine_tb.sv
`timescale 1ns / 1ps

module positional_list_engine_tb;
   import ple_pkg::*;

   localparam int unsigned CAPACITY      = 64;
   localparam int unsigned RANDOM_ITEMS  = 850;
   localparam int unsigned QUIET_TAIL    = 120;   // closing stretch with no sender gaps
   localparam int unsigned STALL_LIMIT   = 400;   // cycles with no transfer at all
   localparam int unsigned SETTLE_CYCLES = 4;     // the response comes in the cycle after its request

   localparam logic signed [DATA_WIDTH-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_WIDTH-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic [POS_WIDTH-1:0]         POS_TOP   = '1;

   // traffic shaping: pushes the list towards full, keeps it mid-level,
   // or drains it towards empty
   typedef enum int {
      PHASE_GROW,
      PHASE_CHURN,
      PHASE_SHRINK
   } traffic_phase_type;

   typedef struct {
      logic signed [DATA_WIDTH-1:0] read_value;
      logic [STATUS_WIDTH-1:0]      status;
      logic [COUNT_WIDTH-1:0]       count;
   } list_rsp_type;

   // Shadow copy of the list. Every accepted request is applied here and
   // the response it must produce is queued; responses are matched in order.
   class list_mirror #(int unsigned DEPTH = 64);
      logic signed [DATA_WIDTH-1:0] cells [DEPTH];
      int unsigned                  fill;
      list_rsp_type                 due_rsp [$];
      int unsigned                  mismatches;

      function new();
         fill       = 0;
         mismatches = 0;
      endfunction

      function int unsigned level();
         return fill;
      endfunction

      function int unsigned outstanding();
         return due_rsp.size();
      endfunction

      // overwrite/remove/read clamp to the last element
      function int unsigned pick_index(logic [POS_WIDTH-1:0] pos);
         return (pos >= fill) ? fill - 1 : pos;
      endfunction

      function void note_request(logic [FUNC_WIDTH-1:0] func, logic [POS_WIDTH-1:0] pos,
                                 logic signed [DATA_WIDTH-1:0] value);
         list_rsp_type r;
         int unsigned  at;
         int unsigned  i;
         r.read_value = '0;
         r.status     = STATUS_OK;
         case (func)
            FUNC_INSERT: begin
               if (fill >= DEPTH) begin
                  r.status = STATUS_FULL;
               end else begin
                  // beyond the tail appends; later elements move up
                  at = (pos >= fill) ? fill : pos;
                  for (i = fill; i > at; i--) cells[i] = cells[i-1];
                  cells[at] = value;
                  fill++;
               end
            end
            FUNC_OVERWRITE: begin
               if (fill == 0) r.status = STATUS_EMPTY;
               else cells[pick_index(pos)] = value;
            end
            FUNC_REMOVE: begin
               if (fill == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  at           = pick_index(pos);
                  r.read_value = cells[at];
                  for (i = at; i + 1 < fill; i++) cells[i] = cells[i+1];
                  fill--;
               end
            end
            FUNC_READ: begin
               if (fill == 0) r.status = STATUS_EMPTY;
               else r.read_value = cells[pick_index(pos)];
            end
            FUNC_CLEAR: fill = 0;
            default: ;   // spare codes: no-op, count reported as is
         endcase
         r.count = COUNT_WIDTH'(fill);
         due_rsp.push_back(r);
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%0t: %s", $time, msg);
      endfunction

      function void check_response(logic signed [DATA_WIDTH-1:0] read_value,
                                   logic [STATUS_WIDTH-1:0] status,
                                   logic [COUNT_WIDTH-1:0] count);
         list_rsp_type e;
         if (due_rsp.size() == 0) begin
            report($sformatf("response with none outstanding: rd=%0d st=%0d cnt=%0d",
                             read_value, status, count));
            return;
         end
         e = due_rsp.pop_front();
         if (read_value !== e.read_value || status !== e.status || count !== e.count)
            report($sformatf({"response mismatch: expected rd=%0d st=%0d cnt=%0d,",
                              " got rd=%0d st=%0d cnt=%0d"},
                             e.read_value, e.status, e.count, read_value, status, count));
      endfunction
   endclass

   logic                         clock        = 1'b0;
   logic                         reset        = 1'b1;
   logic                         start        = 1'b0;
   logic                         busy;
   logic [FUNC_WIDTH-1:0]        req_func     = '0;
   logic [POS_WIDTH-1:0]         req_position = '0;
   logic signed [DATA_WIDTH-1:0] req_value    = '0;
   logic                         rsp_strobe;
   logic signed [DATA_WIDTH-1:0] rsp_read_value;
   logic [STATUS_WIDTH-1:0]      rsp_status;
   logic [COUNT_WIDTH-1:0]       rsp_count;

   list_mirror #(CAPACITY) mirror;
   int unsigned            stalled_cycles = 0;

   positional_list_engine #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_position  (req_position),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_read_value(rsp_read_value),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Both channels sampled on the same edge the DUT sees. The response is
   // checked before the request is noted: a response taken at this edge
   // always belongs to an earlier request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) mirror.check_response(rsp_read_value, rsp_status, rsp_count);
         if (start && !busy) mirror.note_request(req_func, req_position, req_value);
      end
   end

   // Watchdog: any transfer on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles + 1 >= STALL_LIMIT) begin
         $display("positional_list_engine verification failed");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   // Present one request and hold it until the transfer edge.
   // Called just after a rising edge; returns on the edge that takes it.
   task automatic send_op(input logic [FUNC_WIDTH-1:0] func, input logic [POS_WIDTH-1:0] pos,
                          input logic signed [DATA_WIDTH-1:0] value);
      start        <= 1'b1;
      req_func     <= func;
      req_position <= pos;
      req_value    <= value;
      do @(posedge clock); while (busy);
   endtask

   // Sender gap; the payload ports carry junk meanwhile.
   task automatic rest_sender(input int unsigned cycles);
      start        <= 1'b0;
      req_func     <= FUNC_WIDTH'($urandom);
      req_position <= POS_WIDTH'($urandom);
      req_value    <= $urandom;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold off until every outstanding response has come back.
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (mirror.outstanding() != 0);
   endtask

   function automatic logic [FUNC_WIDTH-1:0] choose_func(traffic_phase_type phase);
      int unsigned roll;
      int unsigned ins_lim;
      int unsigned ovw_lim;
      int unsigned rem_lim;
      roll = $urandom_range(0, 99);
      if (roll < 2) return FUNC_CLEAR + FUNC_WIDTH'($urandom_range(1, 3));   // spare codes
      if (roll < 3) return FUNC_CLEAR;
      case (phase)
         PHASE_GROW:  begin ins_lim = 80; ovw_lim = 86; rem_lim = 91; end
         PHASE_CHURN: begin ins_lim = 38; ovw_lim = 52; rem_lim = 76; end
         default:     begin ins_lim = 15; ovw_lim = 25; rem_lim = 82; end
      endcase
      if (roll < ins_lim) return FUNC_INSERT;
      if (roll < ovw_lim) return FUNC_OVERWRITE;
      if (roll < rem_lim) return FUNC_REMOVE;
      return FUNC_READ;
   endfunction

   // head, top code, tail, one past the tail, anywhere, or within the list
   function automatic logic [POS_WIDTH-1:0] pick_position(int unsigned fill);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return POS_TOP;
         2:       return (fill == 0) ? '0 : POS_WIDTH'(fill - 1);
         3:       return POS_WIDTH'(fill);
         4, 5:    return POS_WIDTH'($urandom_range(0, 255));
         default: return (fill == 0) ? '0 : POS_WIDTH'($urandom_range(0, fill - 1));
      endcase
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return VALUE_MAX;
         1:       return VALUE_MIN;
         2:       return '0;
         3:       return -1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      traffic_phase_type phase;
      int unsigned       items_sent;
      int unsigned       run_len;
      int unsigned       k;
      bit                gappy;
      bit                quiet;

      mirror = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // empty list: every access errors, clear is harmless
      send_op(FUNC_READ,      POS_TOP, '0);
      send_op(FUNC_OVERWRITE, '0,      VALUE_MAX);
      send_op(FUNC_REMOVE,    8'd7,    '0);
      send_op(FUNC_CLEAR,     '0,      '0);
      // spare func codes
      send_op(FUNC_CLEAR + 3'd1, POS_TOP, -1);
      send_op(FUNC_CLEAR + 3'd2, '0,      VALUE_MIN);
      send_op(FUNC_CLEAR + 3'd3, 8'd3,    VALUE_MAX);
      // inserts at head, past the tail, and in the middle
      send_op(FUNC_INSERT, '0,      VALUE_MAX);
      send_op(FUNC_INSERT, POS_TOP, VALUE_MIN);
      send_op(FUNC_INSERT, 8'd1,    -1);
      send_op(FUNC_INSERT, '0,      '0);
      send_op(FUNC_INSERT, 8'd2,    32'sh1234_5678);
      // reads: head, clamped tail, middle
      send_op(FUNC_READ, '0,      '0);
      send_op(FUNC_READ, POS_TOP, '0);
      send_op(FUNC_READ, 8'd2,    '0);
      send_op(FUNC_OVERWRITE, POS_TOP, 32'shAAAA_AAAA);
      send_op(FUNC_OVERWRITE, '0,      32'sh5555_5555);
      // removes: middle, clamped tail, head
      send_op(FUNC_REMOVE, 8'd2,    '0);
      send_op(FUNC_REMOVE, POS_TOP, '0);
      send_op(FUNC_REMOVE, '0,      '0);
      send_op(FUNC_READ,   8'd128,  '0);
      send_op(FUNC_CLEAR + 3'd3, '0, '0);   // spare code on a non-empty list
      send_op(FUNC_CLEAR, POS_TOP, -1);
      send_op(FUNC_READ,  '0,      '0);     // empty again after clear

      // sender holds off until the block has answered everything
      wait_drained();

      // --- random ---
      // Phases cycle grow -> churn -> shrink so the list keeps swinging
      // between full (insert refused) and empty (accesses refused).
      items_sent = 0;
      phase      = PHASE_GROW;
      while (items_sent < RANDOM_ITEMS) begin
         run_len = $urandom_range(40, 120);
         gappy   = ($urandom_range(0, 2) != 0);   // some runs are back to back
         for (k = 0; k < run_len && items_sent < RANDOM_ITEMS; k++) begin
            quiet = (items_sent + QUIET_TAIL >= RANDOM_ITEMS);
            if (gappy && !quiet && $urandom_range(0, 4) == 0)
               rest_sender($urandom_range(1, 6));
            send_op(choose_func(phase), pick_position(mirror.level()), pick_value());
            items_sent++;
         end
         if (items_sent + QUIET_TAIL < RANDOM_ITEMS && $urandom_range(0, 2) == 0)
            wait_drained();
         case (phase)
            PHASE_GROW:  phase = PHASE_CHURN;
            PHASE_CHURN: phase = PHASE_SHRINK;
            default:     phase = PHASE_GROW;
         endcase
      end

      // let the last responses land, then a few idle cycles for strays
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mirror.mismatches == 0 && mirror.outstanding() == 0)
         $display("positional_list_engine verification clean");
      else
         $display("positional_list_engine verification failed");
      $finish;
   end

endmodule
